// ===== src/bts_pkg.sv =====
// Package: request/response payload types and constants of the burst scheduler.
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

   // Outcome of a burst start request
   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_ACCEPTED = 2'd1,
      STATUS_REJECTED = 2'd2
   } start_status_type;

   // Widths of the slot index, burst count and silence gap, and the default silence gap after reset
   localparam int unsigned SLOT_BITS   = 3;
   localparam int unsigned COUNT_BITS  = 8;
   localparam int unsigned GAP_BITS    = 16;
   localparam logic [GAP_BITS-1:0] DEFAULT_GAP = 16'd20;

   // One tick request
   typedef struct packed {
      logic                  start_req;
      logic [SLOT_BITS-1:0]  start_slot;
      logic [COUNT_BITS-1:0] start_count;
      logic [GAP_BITS-1:0]   start_silence;
      logic                  rx_heard;
      logic                  link_up;
   } req_payload_type;

   // One tick response
   typedef struct packed {
      logic                  send;
      logic [SLOT_BITS-1:0]  send_slot;
      logic [COUNT_BITS-1:0] remaining;
      start_status_type      start_status;
      logic                  aborted;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== src/bts_chan_if.sv =====
// Interface: valid/ready channel carrying one payload.
`timescale 1ns / 1ps
`default_nettype none

interface bts_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/bts_in_stage.sv =====
// Input register stage holding one request until the scheduler takes it.
`timescale 1ns / 1ps
`default_nettype none

module bts_in_stage (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire bts_pkg::req_payload_type in_payload,
   output logic                          in_ready,
   input  wire logic                     advance,
   output logic                          out_valid,
   output bts_pkg::req_payload_type      out_payload
);

   logic                     valid_ff;
   logic                     valid_in;
   logic                     load;
   bts_pkg::req_payload_type payload_ff;

   // Free slot when empty or when the held request leaves this cycle
   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= in_payload;
      end
   end

   assign out_valid   = valid_ff;
   assign out_payload = payload_ff;

endmodule

`default_nettype wire

// ===== src/bts_sched.sv =====
// Burst state, silence-gap check and the response register.
`timescale 1ns / 1ps
`default_nettype none

module bts_sched #(
   parameter int unsigned SLOT_COUNT   = 5,
   parameter int unsigned ELAPSED_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     item_valid,
   input  wire bts_pkg::req_payload_type item,
   output logic                          take,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output bts_pkg::rsp_payload_type      rsp_payload
);

   localparam int unsigned CMP_BITS =
      (ELAPSED_BITS > bts_pkg::GAP_BITS) ? ELAPSED_BITS : bts_pkg::GAP_BITS;
   localparam int unsigned SLOT_CMP_BITS = bts_pkg::SLOT_BITS + 1;

   // Burst state
   logic [bts_pkg::COUNT_BITS-1:0] pending_ff, pending_in;
   logic [bts_pkg::SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [bts_pkg::GAP_BITS-1:0]   gap_ff, gap_in;
   logic [ELAPSED_BITS-1:0]        since_rx_ff, since_rx_in;
   logic [ELAPSED_BITS-1:0]        since_tx_ff, since_tx_in;
   logic                           tx_seen_ff, tx_seen_in;
   logic                           armed_ff, armed_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   bts_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [ELAPSED_BITS-1:0] rx_tick;
   logic [ELAPSED_BITS-1:0] tx_tick;
   logic                    bad_start;
   logic                    rx_quiet;
   logic                    tx_quiet;

   // Take a request when the response register is free or draining
   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   // Saturating elapsed counters for this tick
   assign rx_tick = item.rx_heard ? '0 :
                    ((since_rx_ff == '1) ? since_rx_ff : since_rx_ff + ELAPSED_BITS'(1));
   assign tx_tick = (since_tx_ff == '1) ? since_tx_ff : since_tx_ff + ELAPSED_BITS'(1);

   // Quiet tests; a saturated counter passes any gap
   assign rx_quiet = (rx_tick == '1) || (CMP_BITS'(rx_tick) >= CMP_BITS'(gap_ff));
   assign tx_quiet = (tx_tick == '1) || (CMP_BITS'(tx_tick) >= CMP_BITS'(gap_ff));

   assign bad_start = (SLOT_CMP_BITS'(item.start_slot) >= SLOT_CMP_BITS'(SLOT_COUNT))
                      || (item.start_count == '0);

   // Next state and response for the request in the input register
   always_comb begin
      pending_in  = pending_ff;
      slot_in     = slot_ff;
      gap_in      = gap_ff;
      since_rx_in = rx_tick;
      since_tx_in = tx_tick;
      tx_seen_in  = tx_seen_ff;
      armed_in    = armed_ff;
      rsp_in.send         = 1'b0;
      rsp_in.send_slot    = '0;
      rsp_in.start_status = bts_pkg::STATUS_NONE;
      rsp_in.aborted      = 1'b0;

      if (item.start_req) begin
         priority if (bad_start) begin
            rsp_in.start_status = bts_pkg::STATUS_REJECTED;
         end else if (!item.link_up) begin
            rsp_in.start_status = bts_pkg::STATUS_REJECTED;
            pending_in = '0;
            armed_in   = 1'b0;
         end else begin
            rsp_in.start_status = bts_pkg::STATUS_ACCEPTED;
            pending_in  = item.start_count;
            slot_in     = item.start_slot;
            gap_in      = item.start_silence;
            since_tx_in = '0;
            tx_seen_in  = 1'b0;
            armed_in    = 1'b1;
         end
      end else if ((pending_ff != '0) && armed_ff) begin
         if (!item.link_up) begin
            pending_in     = '0;
            armed_in       = 1'b0;
            rsp_in.aborted = 1'b1;
         end else if (rx_quiet && (!tx_seen_ff || tx_quiet)) begin
            rsp_in.send      = 1'b1;
            rsp_in.send_slot = slot_ff;
            pending_in       = pending_ff - bts_pkg::COUNT_BITS'(1);
            since_tx_in      = '0;
            tx_seen_in       = 1'b1;
            if (pending_ff == bts_pkg::COUNT_BITS'(1)) begin
               armed_in = 1'b0;
            end
         end
      end

      rsp_in.remaining = pending_in;
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and burst state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         slot_ff      <= '0;
         gap_ff       <= bts_pkg::DEFAULT_GAP;
         since_rx_ff  <= '1;
         since_tx_ff  <= '0;
         tx_seen_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            pending_ff  <= pending_in;
            slot_ff     <= slot_in;
            gap_ff      <= gap_in;
            since_rx_ff <= since_rx_in;
            since_tx_ff <= since_tx_in;
            tx_seen_ff  <= tx_seen_in;
            armed_ff    <= armed_in;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== src/burst_tx_silence_gap_scheduler_core.sv =====
// Burst transmit scheduler with silence gap: top level.
// A request passes the input register, then the result register, before its response is valid.
// One request per cycle unless rsp_ready stalls; one state update per request, the only loop.
// Reset: synchronous, active high; no burst, gap 20, receive timer saturated, send timer zero.
// Both channel stages empty after reset; a request can be taken in the first cycle.
`timescale 1ns / 1ps
`default_nettype none

module burst_tx_silence_gap_scheduler_core #(
   parameter int unsigned SLOT_COUNT   = 5,
   parameter int unsigned ELAPSED_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   bts_chan_if.sink   req_chan,
   bts_chan_if.source rsp_chan
);

   logic                     item_valid;
   logic                     take;
   bts_pkg::req_payload_type item;

   // Input register stage
   bts_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_payload  (req_chan.payload),
      .in_ready    (req_chan.ready),
      .advance     (take),
      .out_valid   (item_valid),
      .out_payload (item)
   );

   // Scheduler logic and response register
   bts_sched #(
      .SLOT_COUNT   (SLOT_COUNT),
      .ELAPSED_BITS (ELAPSED_BITS)
   ) u_sched (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .take        (take),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_payload (rsp_chan.payload)
   );

`ifndef SYNTHESIS
   // A tick with a start request never sends nor aborts
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.payload.start_status != bts_pkg::STATUS_NONE)
      |-> !rsp_chan.payload.send && !rsp_chan.payload.aborted)
      else $error("send or abort on a start tick");

   // An abort empties the burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.aborted |-> rsp_chan.payload.remaining == '0)
      else $error("abort left transmissions pending");

   // Sends go out only on a valid slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.send
      |-> (4'(rsp_chan.payload.send_slot) < 4'(SLOT_COUNT)))
      else $error("send on an out-of-range slot");

   // Without a send the slot field stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.send |-> rsp_chan.payload.send_slot == '0)
      else $error("slot shown without a send");
`endif

endmodule

`default_nettype wire
